[hw/rtl/btm_pkg.sv]
package btm_pkg;

	localparam int unsigned PAT_ROWS      = 3;
	localparam int unsigned PAT_COLS      = 20;
	localparam int unsigned MAX_WIDTH_DEF = 128;

	localparam int unsigned MASK_W  = 20;
	localparam int unsigned IWID_W  = 8;
	localparam int unsigned MATCH_W = 14;
	localparam int unsigned SET_W   = 15;
	localparam int unsigned CNT_W   = 6;    // up to 60 new marks per window
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [MASK_W-1:0]  MASK_TOP_RST = 20'd262144;
	localparam logic [MASK_W-1:0]  MASK_MID_RST = 20'd923745;
	localparam logic [MASK_W-1:0]  MASK_BOT_RST = 20'd74898;
	localparam logic [IWID_W-1:0]  IWID_RST     = 8'd96;

	localparam logic [MATCH_W-1:0] MATCH_CAP = '1;
	localparam logic [SET_W-1:0]   SET_CAP   = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MASK_TOP = 2'd0,
		REG_MASK_MID = 2'd1,
		REG_MASK_BOT = 2'd2,
		REG_IMG_WID  = 2'd3
	} reg_idx_t;

	// one line memory entry: the two older rows of one column, rolled
	typedef struct packed {
		logic m1;
		logic m0;
		logic p1;
		logic p0;
	} line_ent_t;

endpackage

[hw/rtl/btm_if.sv]
interface btm_pix_if;
	logic valid;
	logic ready;
	logic pixel_set;
	logic frame_end;
	modport source (output valid, pixel_set, frame_end, input ready);
	modport sink (input valid, pixel_set, frame_end, output ready);
endinterface

interface btm_res_if;
	logic        valid;
	logic        ready;
	logic [13:0] match_count;
	logic [14:0] unmarked_count;
	modport source (output valid, match_count, unmarked_count, input ready);
	modport sink (input valid, match_count, unmarked_count, output ready);
endinterface

interface btm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [19:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/binary_template_match_marker_core.sv]
// Channel  Dir  Payload                          Transaction
// pix      in   pixel_set, frame_end             valid & ready, one pixel
// res      out  match_count, unmarked_count      valid & ready, one per frame
// cfg      in   index (0..3), data               valid & ready, ready always high
//
// One pixel per cycle while res is not stalled; after its frame_end pixel is
// taken, a result passes the line memory read, window test and totals stages.
// The 20-column window lives in registers; older rows sit in a line memory
// of MAX_WIDTH entries, read into a register alongside stage 1.
// arst_n clears control, counters and line memory valid bits; no sweep.
// A stalled result freezes the whole pipe, so pix.ready follows res.ready.
module binary_template_match_marker_core
	import btm_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	btm_pix_if.sink pix,
	btm_res_if.source res,
	btm_cfg_if.sink cfg
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = ((CW > IWID_W) ? CW : IWID_W) + 1;
	localparam logic [WW-1:0] MAXW_W = WW'(MAX_WIDTH);
	localparam logic [WW-1:0] PCOL_W = WW'(PAT_COLS);

	// ---------------- configuration ----------------
	logic [MASK_W-1:0] mask_q [PAT_ROWS];
	logic [IWID_W-1:0] iwid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0] <= MASK_TOP_RST;
			mask_q[1] <= MASK_MID_RST;
			mask_q[2] <= MASK_BOT_RST;
			iwid_q    <= IWID_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MASK_TOP: mask_q[0] <= cfg.data;
				REG_MASK_MID: mask_q[1] <= cfg.data;
				REG_MASK_BOT: mask_q[2] <= cfg.data;
				REG_IMG_WID:  iwid_q    <= cfg.data[IWID_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipe control ----------------
	logic en;
	logic res_valid_q;
	assign en        = !res_valid_q || res.ready;
	assign pix.ready = en;

	logic acc;
	assign acc = pix.valid && en;

	// ---------------- stage 1: raster position, memory read ----------------
	logic [WW-1:0] iw_ext, eff_w, col_ext, colc_ext;
	logic [CW-1:0] col_q, colc;
	logic [1:0]    row_q;   // saturates at 2, enough for the window test
	logic          test_c;

	always_comb begin
		iw_ext = WW'(iwid_q);
		if (iw_ext < PCOL_W) begin
			eff_w = PCOL_W;
		end else if (iw_ext > MAXW_W) begin
			eff_w = MAXW_W;
		end else begin
			eff_w = iw_ext;
		end
		col_ext  = WW'(col_q);
		colc_ext = (col_ext >= eff_w) ? (eff_w - WW'(1)) : col_ext;
		colc     = colc_ext[CW-1:0];
		test_c   = (row_q == 2'd2) && (colc_ext >= PCOL_W - WW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (pix.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (colc_ext + WW'(1) >= eff_w) begin
				col_q <= '0;
				if (row_q != 2'd2) begin
					row_q <= row_q + 2'd1;
				end
			end else begin
				col_q <= colc + CW'(1);
			end
		end
	end

	logic          v_s1, pix_s1, last_s1, test_s1;
	logic [CW-1:0] col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pix.pixel_set;
			last_s1 <= pix.frame_end;
			test_s1 <= test_c;
			col_s1  <= colc;
		end
	end

	// ---------------- line memory ----------------
	logic          win_vld_q [PAT_COLS];
	logic [CW-1:0] win_addr_q [PAT_COLS];
	logic [2:0]    win_pix_q [PAT_COLS];
	logic [2:0]    win_mk_q [PAT_COLS];

	logic      mem_we, mem_clr;
	line_ent_t mem_wd, mem_rd;

	// the column leaving the window goes back already rolled by one row
	assign mem_we  = en && v_s1 && !last_s1 && win_vld_q[0];
	assign mem_clr = en && v_s1 && last_s1;
	assign mem_wd  = '{m1: win_mk_q[0][2], m0: win_mk_q[0][1],
	                   p1: win_pix_q[0][2], p0: win_pix_q[0][1]};

	btm_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (colc),
		.wr_en   (mem_we),
		.wr_addr (win_addr_q[0]),
		.wr_data (mem_wd),
		.clr     (mem_clr),
		.rd_data (mem_rd)
	);

	// ---------------- stage 2: window shift, test, mark ----------------
	line_ent_t     ent;
	logic [2:0]    nw_pix [PAT_COLS];
	logic [2:0]    nw_mk [PAT_COLS];
	logic          nw_vld [PAT_COLS];
	logic [CW-1:0] nw_addr [PAT_COLS];
	logic          hit;
	logic [CNT_W-1:0] new_cnt;

	always_comb begin
		// at the minimum width the leaving column is the one coming back
		if (win_vld_q[0] && win_addr_q[0] == col_s1) begin
			ent = mem_wd;
		end else begin
			ent = mem_rd;
		end
		for (int k = 0; k < PAT_COLS - 1; k++) begin
			nw_pix[k]  = win_pix_q[k+1];
			nw_mk[k]   = win_mk_q[k+1];
			nw_vld[k]  = win_vld_q[k+1];
			nw_addr[k] = win_addr_q[k+1];
		end
		nw_pix[PAT_COLS-1]  = {pix_s1, ent.p1, ent.p0};
		nw_mk[PAT_COLS-1]   = {1'b0, ent.m1, ent.m0};
		nw_vld[PAT_COLS-1]  = 1'b1;
		nw_addr[PAT_COLS-1] = col_s1;

		hit = test_s1;
		for (int i = 0; i < PAT_ROWS; i++) begin
			for (int j = 0; j < PAT_COLS; j++) begin
				if (mask_q[i][j] && !nw_pix[j][i]) begin
					hit = 1'b0;
				end
			end
		end

		new_cnt = '0;
		for (int i = 0; i < PAT_ROWS; i++) begin
			for (int j = 0; j < PAT_COLS; j++) begin
				new_cnt = new_cnt + CNT_W'(hit && mask_q[i][j] && !nw_mk[j][i]);
				nw_mk[j][i] = nw_mk[j][i] | (hit & mask_q[i][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PAT_COLS; k++) begin
				win_vld_q[k] <= 1'b0;
			end
		end else if (en && v_s1) begin
			for (int k = 0; k < PAT_COLS; k++) begin
				win_vld_q[k] <= nw_vld[k] && !last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			for (int k = 0; k < PAT_COLS; k++) begin
				win_pix_q[k]  <= nw_pix[k];
				win_mk_q[k]   <= nw_mk[k];
				win_addr_q[k] <= nw_addr[k];
			end
		end
	end

	logic             v_s2, pix_s2, last_s2, hit_s2;
	logic [CNT_W-1:0] cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			pix_s2  <= pix_s1;
			last_s2 <= last_s1;
			hit_s2  <= hit;
			cnt_s2  <= new_cnt;
		end
	end

	// ---------------- stage 3: totals and result ----------------
	logic [SET_W-1:0]   set_q, mark_q, set_n, mark_n, unm_n;
	logic [MATCH_W-1:0] match_q, match_n;
	logic [SET_W:0]     mark_sum;

	always_comb begin
		set_n = set_q;
		if (pix_s2 && set_q != SET_CAP) begin
			set_n = set_q + SET_W'(1);
		end
		mark_sum = {1'b0, mark_q} + (SET_W+1)'(cnt_s2);
		mark_n   = mark_sum[SET_W] ? SET_CAP : mark_sum[SET_W-1:0];
		match_n  = match_q;
		if (hit_s2 && match_q != MATCH_CAP) begin
			match_n = match_q + MATCH_W'(1);
		end
		unm_n = (set_n > mark_n) ? (set_n - mark_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q       <= '0;
			mark_q      <= '0;
			match_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s2 && last_s2;
			if (v_s2) begin
				if (last_s2) begin
					set_q   <= '0;
					mark_q  <= '0;
					match_q <= '0;
				end else begin
					set_q   <= set_n;
					mark_q  <= mark_n;
					match_q <= match_n;
				end
			end
		end
	end

	logic [MATCH_W-1:0] res_match_q;
	logic [SET_W-1:0]   res_unm_q;

	always_ff @(posedge clk) begin
		if (en && v_s2 && last_s2) begin
			res_match_q <= match_n;
			res_unm_q   <= unm_n;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.match_count    = res_match_q;
	assign res.unmarked_count = res_unm_q;

	// ---------------- checks ----------------
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix.frame_end |=> col_q == '0 && row_q == 2'd0)
		else $error("raster position not cleared after frame end");

	a_hit_needs_test: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && hit |-> test_s1)
		else $error("match outside a valid window origin");

	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> en && !mem_clr)
		else $error("line memory written while stalled or clearing");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(v_s2 && last_s2))
		else $error("result without a frame end transaction");

endmodule

[hw/rtl/btm_line_mem.sv]
module btm_line_mem
	import btm_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  line_ent_t                    wr_data,
	input  logic                         clr,
	output line_ent_t                    rd_data
);

	line_ent_t              mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0]   vld_q;
	line_ent_t              rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// valid bits stand in for clearing the rows at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// write-first bypass; a clear kills the read in flight
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (clr) begin
				rd_q <= '0;
			end else if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_data;
			end else if (vld_q[rd_addr]) begin
				rd_q <= mem[rd_addr];
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign rd_data = rd_q;

endmodule
